>>> rtl/adam_weight_update_core_assert.svh
// Assertion macros shared by the Adam weight update RTL.
// Users must provide aclk and aresetn in the including scope.
`ifndef ADAM_WEIGHT_UPDATE_CORE_ASSERT_SVH
`define ADAM_WEIGHT_UPDATE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AWU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("awu: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define AWU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("awu: next-cycle check failed");

`endif

>>> rtl/awu_pkg.sv
// Shared types and constants for the Adam weight update core.
// No dependencies; imported by adam_weight_update_core and awu_div_pipe.
package awu_pkg;

    localparam int IDX_W      = 12;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic KIND_STEP = 1'b0;
    localparam logic KIND_ELEM = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_FIRST    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_SECOND   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STABILIZER    = 4'd3;

    localparam logic [23:0] LR_RESET    = 24'd16777;
    localparam logic [15:0] BETA1_RESET = 16'd58982;
    localparam logic [15:0] BETA2_RESET = 16'd65470;
    localparam logic [23:0] STAB_RESET  = 24'd1;

    localparam logic [32:0]        ONE_Q32 = 33'h1_0000_0000;
    localparam logic signed [17:0] ONE_Q16 = 18'sd65536;
    localparam logic [31:0]        MAX_POS = 32'h7FFF_FFFF;

    typedef struct packed {
        logic                     kind;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] gradient;
        logic signed [DATA_W-1:0] weight;
    } awu_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_index;
        logic signed [DATA_W-1:0] new_weight;
        logic                     saturated;
    } awu_out_t;

endpackage

>>> rtl/adam_weight_update_core.sv
// Adam weight update core: fully pipelined, one element update accepted per cycle while
// neither a held output result nor the clearing pass stalls the input. Each result passes
// through the two bit-serial divider chains and the bit-pair square root chain.
// New-step items take effect at their transfer and produce no result.
// Reset is synchronous; afterwards a clearing pass zeroes both moment RAMs, one entry
// per cycle over all ENTRIES addresses, while no input is taken. Depends on awu_pkg,
// awu_ram, awu_div_pipe and adam_weight_update_core_assert.svh.
`include "adam_weight_update_core_assert.svh"

module adam_weight_update_core #(
    parameter int ENTRIES   = 4096,
    parameter int FRAC_BITS = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  awu_pkg::awu_in_t                   s_payload,
    output logic                               m_valid,
    input  logic                               m_ready,
    output awu_pkg::awu_out_t                  m_payload,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [awu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [awu_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import awu_pkg::*;

    localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SQ_RW  = (32 + FRAC_BITS) / 2;
    localparam int SQ_PW  = 2 * SQ_RW;
    localparam int NSH    = (FRAC_BITS > 24) ? FRAC_BITS - 24 : 0;
    localparam int DSH    = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;
    localparam int NUM_W  = 56;
    localparam int N_W    = NUM_W + NSH;
    localparam int D_W    = 32 + DSH;
    localparam int CMP_W  = (N_W > D_W + 31) ? N_W : D_W + 31;
    localparam logic [31:0] ENTRIES_W = 32'(ENTRIES);

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic signed [31:0] w;
        logic              sat;
        logic              neg;
        logic              bz;
        logic              ovf;
        logic [31:0]       mag;
    } cor_side_t;

    typedef struct packed {
        logic        bz;
        logic        ovf;
        logic [31:0] mag;
    } vcor_side_t;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] w;
        logic               sat;
        logic               neg;
        logic [NUM_W-1:0]   num;
    } sq_side_t;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] w;
        logic               sat;
        logic               neg;
        logic               ovf;
    } st_side_t;

    // Configuration and step state.
    logic [23:0] lr_reg, stab_reg;
    logic [15:0] beta1_reg, beta2_reg;
    logic [31:0] step_cnt_reg;
    logic [32:0] pow1_reg, pow2_reg;
    logic [48:0] pow1_prod, pow2_prod;

    // Flow control and clearing.
    logic          en;
    logic          accept;
    logic          elem_acc;
    logic          step_acc;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_cnt_reg;

    // Accept stage arithmetic.
    logic [31:0] gmag;
    logic [63:0] gprod, gshift;
    logic        gsq_sat;

    // Stage 1: moment read-modify-write.
    logic               p1_valid_reg;
    logic [AW-1:0]      p1_addr_reg;
    logic [IDX_W-1:0]   p1_idx_reg;
    logic signed [31:0] p1_g_reg, p1_w_reg;
    logic [30:0]        p1_gsq_reg;
    logic               p1_sat_reg;
    logic [32:0]        p1_bias1_reg, p1_bias2_reg;

    logic [31:0]        m_rdata, v_rdata;
    logic signed [31:0] m_old, v_old;
    logic signed [17:0] b1_s, b2_s, omb1_s, omb2_s;
    logic signed [50:0] m_full, v_full;
    logic signed [31:0] m_new, v_new;
    logic               fwd_hit;
    logic               fwd_valid_reg;
    logic [AW-1:0]      fwd_addr_reg;
    logic [31:0]        fwd_m_reg, fwd_v_reg;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        m_wdata, v_wdata;

    // Stage 2: divider setup.
    logic               p2_valid_reg;
    logic [IDX_W-1:0]   p2_idx_reg;
    logic signed [31:0] p2_w_reg, p2_m_reg, p2_v_reg;
    logic               p2_sat_reg;
    logic [32:0]        p2_bias1_reg, p2_bias2_reg;
    cor_side_t          mside_in, mside_out;
    vcor_side_t         vside_in, vside_out;
    logic [32:0]        mrem0, vrem0;
    logic               mdiv_valid, vdiv_valid;
    logic [31:0]        mdiv_quo, vdiv_quo;

    // Stage 3: clamp of corrected moments.
    logic [32:0]        mcand, vcand, mlim;
    logic               mclamp, vclamp;
    logic               p3_valid_reg;
    logic [IDX_W-1:0]   p3_idx_reg;
    logic signed [31:0] p3_w_reg;
    logic               p3_sat_reg, p3_neg_reg;
    logic [31:0]        p3_mhat_reg;
    logic [30:0]        p3_vhat_reg;
    logic [NUM_W-1:0]   num;

    // Square root chain.
    logic               sq_valid_reg [SQ_RW];
    logic [SQ_RW+1:0]   sq_rem_reg   [SQ_RW];
    logic [SQ_RW-1:0]   sq_root_reg  [SQ_RW];
    logic [SQ_PW-1:0]   sq_rad_reg   [SQ_RW];
    sq_side_t           sq_side_reg  [SQ_RW];
    logic               sq_valid_c   [SQ_RW+1];
    logic [SQ_RW+1:0]   sq_rem_c     [SQ_RW+1];
    logic [SQ_RW-1:0]   sq_root_c    [SQ_RW+1];
    logic [SQ_PW-1:0]   sq_rad_c     [SQ_RW+1];
    sq_side_t           sq_side_c    [SQ_RW+1];
    logic [SQ_RW+1:0]   sq_t         [SQ_RW];
    logic [SQ_RW+1:0]   sq_trial     [SQ_RW];
    logic               sq_ge        [SQ_RW];

    // Stage 4: step divider setup.
    logic [31:0]        denom_sum, denom;
    logic [D_W-1:0]     dvsr;
    logic [N_W-1:0]     dvnd;
    logic               p4_valid_reg;
    st_side_t           p4_side_reg;
    logic [D_W-1:0]     p4_div_reg, p4_rem_reg;
    logic [30:0]        p4_low_reg;
    logic               sdiv_valid;
    logic [30:0]        sdiv_quo;
    st_side_t           sside_out;

    // Output.
    logic [30:0]        smag;
    logic signed [33:0] nw_full;
    awu_out_t           out_next;
    logic               out_valid_reg;
    awu_out_t           out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg    <= LR_RESET;
            beta1_reg <= BETA1_RESET;
            beta2_reg <= BETA2_RESET;
            stab_reg  <= STAB_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LEARNING_RATE: lr_reg    <= cfg_data;
                CFG_BETA_FIRST:    beta1_reg <= cfg_data[15:0];
                CFG_BETA_SECOND:   beta2_reg <= cfg_data[15:0];
                CFG_STABILIZER:    stab_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en       = !out_valid_reg || m_ready || !sdiv_valid;
    assign s_ready  = en && !clr_busy_reg;
    assign accept   = s_valid && s_ready;
    assign step_acc = accept && (s_payload.kind == KIND_STEP);
    assign elem_acc = accept && (s_payload.kind == KIND_ELEM)
                      && (32'(s_payload.index) < ENTRIES_W);

    assign pow1_prod = 49'(pow1_reg) * 49'(beta1_reg);
    assign pow2_prod = 49'(pow2_reg) * 49'(beta2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_cnt_reg <= '0;
            pow1_reg     <= ONE_Q32;
            pow2_reg     <= ONE_Q32;
        end else if (step_acc) begin
            if (step_cnt_reg != 32'hFFFF_FFFF) begin
                step_cnt_reg <= step_cnt_reg + 32'd1;
            end
            pow1_reg <= pow1_prod[48:16];
            pow2_reg <= pow2_prod[48:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(ENTRIES - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign gmag    = s_payload.gradient[31] ? 32'(-s_payload.gradient) : s_payload.gradient;
    assign gprod   = 64'(gmag) * 64'(gmag);
    assign gshift  = gprod >> FRAC_BITS;
    assign gsq_sat = gshift > 64'(MAX_POS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= elem_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_addr_reg  <= AW'(s_payload.index);
            p1_idx_reg   <= s_payload.index;
            p1_g_reg     <= s_payload.gradient;
            p1_w_reg     <= s_payload.weight;
            p1_gsq_reg   <= gsq_sat ? MAX_POS[30:0] : gshift[30:0];
            p1_sat_reg   <= gsq_sat;
            p1_bias1_reg <= ONE_Q32 - pow1_reg;
            p1_bias2_reg <= ONE_Q32 - pow2_reg;
        end
    end

    awu_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_first_moment (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (m_wdata),
        .re    (elem_acc),
        .raddr (AW'(s_payload.index)),
        .rdata (m_rdata)
    );

    awu_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_second_moment (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (v_wdata),
        .re    (elem_acc),
        .raddr (AW'(s_payload.index)),
        .rdata (v_rdata)
    );

    assign fwd_hit = fwd_valid_reg && (fwd_addr_reg == p1_addr_reg);
    assign m_old   = fwd_hit ? fwd_m_reg : m_rdata;
    assign v_old   = fwd_hit ? fwd_v_reg : v_rdata;
    assign b1_s    = {2'b00, beta1_reg};
    assign b2_s    = {2'b00, beta2_reg};
    assign omb1_s  = ONE_Q16 - b1_s;
    assign omb2_s  = ONE_Q16 - b2_s;
    assign m_full  = b1_s * m_old + omb1_s * p1_g_reg;
    assign v_full  = b2_s * v_old + omb2_s * $signed({1'b0, p1_gsq_reg});
    assign m_new   = m_full[47:16];
    assign v_new   = v_full[47:16];

    assign ram_we    = clr_busy_reg || (en && p1_valid_reg);
    assign ram_waddr = clr_busy_reg ? clr_cnt_reg : p1_addr_reg;
    assign m_wdata   = clr_busy_reg ? 32'd0 : m_new;
    assign v_wdata   = clr_busy_reg ? 32'd0 : v_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (en && p1_valid_reg) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && p1_valid_reg) begin
            fwd_addr_reg <= p1_addr_reg;
            fwd_m_reg    <= m_new;
            fwd_v_reg    <= v_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_idx_reg   <= p1_idx_reg;
            p2_w_reg     <= p1_w_reg;
            p2_m_reg     <= m_new;
            p2_v_reg     <= v_new;
            p2_sat_reg   <= p1_sat_reg;
            p2_bias1_reg <= p1_bias1_reg;
            p2_bias2_reg <= p1_bias2_reg;
        end
    end

    always_comb begin
        mside_in.idx = p2_idx_reg;
        mside_in.w   = p2_w_reg;
        mside_in.sat = p2_sat_reg;
        mside_in.neg = p2_m_reg[31];
        mside_in.mag = p2_m_reg[31] ? 32'(-p2_m_reg) : p2_m_reg;
        mside_in.bz  = (p2_bias1_reg == '0);
        mside_in.ovf = !mside_in.bz && ({1'b0, mside_in.mag} >= p2_bias1_reg);
        mrem0        = (mside_in.bz || mside_in.ovf) ? '0 : {1'b0, mside_in.mag};
        vside_in.mag = p2_v_reg;
        vside_in.bz  = (p2_bias2_reg == '0);
        vside_in.ovf = !vside_in.bz && ({1'b0, vside_in.mag} >= p2_bias2_reg);
        vrem0        = (vside_in.bz || vside_in.ovf) ? '0 : {1'b0, vside_in.mag};
    end

    awu_div_pipe #(.DIV_W(33), .QUO_W(32), .SIDE_W($bits(cor_side_t))) u_mdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p2_valid_reg),
        .in_rem    (mrem0),
        .in_low    (32'd0),
        .in_div    (p2_bias1_reg),
        .in_side   (mside_in),
        .out_valid (mdiv_valid),
        .out_quo   (mdiv_quo),
        .out_side  (mside_out)
    );

    awu_div_pipe #(.DIV_W(33), .QUO_W(32), .SIDE_W($bits(vcor_side_t))) u_vdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p2_valid_reg),
        .in_rem    (vrem0),
        .in_low    (32'd0),
        .in_div    (p2_bias2_reg),
        .in_side   (vside_in),
        .out_valid (vdiv_valid),
        .out_quo   (vdiv_quo),
        .out_side  (vside_out)
    );

    always_comb begin
        mcand  = mside_out.bz ? {1'b0, mside_out.mag}
               : (mside_out.ovf ? ONE_Q32 : {1'b0, mdiv_quo});
        vcand  = vside_out.bz ? {1'b0, vside_out.mag}
               : (vside_out.ovf ? ONE_Q32 : {1'b0, vdiv_quo});
        mlim   = mside_out.neg ? 33'h0_8000_0000 : {1'b0, MAX_POS};
        mclamp = mcand > mlim;
        vclamp = vcand > {1'b0, MAX_POS};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p3_valid_reg <= mdiv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_idx_reg  <= mside_out.idx;
            p3_w_reg    <= mside_out.w;
            p3_neg_reg  <= mside_out.neg;
            p3_sat_reg  <= mside_out.sat || mclamp || vclamp;
            p3_mhat_reg <= mclamp ? mlim[31:0] : mcand[31:0];
            p3_vhat_reg <= vclamp ? MAX_POS[30:0] : vcand[30:0];
        end
    end

    assign num = NUM_W'(lr_reg) * NUM_W'(p3_mhat_reg);

    always_comb begin
        sq_valid_c[0]    = p3_valid_reg;
        sq_rem_c[0]      = '0;
        sq_root_c[0]     = '0;
        sq_rad_c[0]      = SQ_PW'(p3_vhat_reg) << FRAC_BITS;
        sq_side_c[0].idx = p3_idx_reg;
        sq_side_c[0].w   = p3_w_reg;
        sq_side_c[0].sat = p3_sat_reg;
        sq_side_c[0].neg = p3_neg_reg;
        sq_side_c[0].num = num;
        for (int k = 0; k < SQ_RW; k++) begin
            sq_valid_c[k+1] = sq_valid_reg[k];
            sq_rem_c[k+1]   = sq_rem_reg[k];
            sq_root_c[k+1]  = sq_root_reg[k];
            sq_rad_c[k+1]   = sq_rad_reg[k];
            sq_side_c[k+1]  = sq_side_reg[k];
        end
        for (int k = 0; k < SQ_RW; k++) begin
            sq_t[k]     = {sq_rem_c[k][SQ_RW-1:0], sq_rad_c[k][SQ_PW-1 -: 2]};
            sq_trial[k] = {sq_root_c[k], 2'b01};
            sq_ge[k]    = sq_t[k] >= sq_trial[k];
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < SQ_RW; k++) begin
            if (!aresetn) begin
                sq_valid_reg[k] <= 1'b0;
            end else if (en) begin
                sq_valid_reg[k] <= sq_valid_c[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQ_RW; k++) begin
                sq_rem_reg[k]  <= sq_ge[k] ? sq_t[k] - sq_trial[k] : sq_t[k];
                sq_root_reg[k] <= {sq_root_c[k][SQ_RW-2:0], sq_ge[k]};
                sq_rad_reg[k]  <= {sq_rad_c[k][SQ_PW-3:0], 2'b00};
                sq_side_reg[k] <= sq_side_c[k];
            end
        end
    end

    assign denom_sum = 32'(sq_root_c[SQ_RW]) + 32'(stab_reg);
    assign denom     = (denom_sum == 32'd0) ? 32'd1 : denom_sum;
    assign dvsr      = D_W'(denom) << DSH;
    assign dvnd      = N_W'(sq_side_c[SQ_RW].num) << NSH;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_valid_reg <= 1'b0;
        end else if (en) begin
            p4_valid_reg <= sq_valid_c[SQ_RW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p4_side_reg.idx <= sq_side_c[SQ_RW].idx;
            p4_side_reg.w   <= sq_side_c[SQ_RW].w;
            p4_side_reg.sat <= sq_side_c[SQ_RW].sat;
            p4_side_reg.neg <= sq_side_c[SQ_RW].neg;
            p4_side_reg.ovf <= CMP_W'(dvnd) >= (CMP_W'(dvsr) << 31);
            p4_div_reg      <= dvsr;
            p4_rem_reg      <= D_W'(dvnd >> 31);
            p4_low_reg      <= dvnd[30:0];
        end
    end

    awu_div_pipe #(.DIV_W(D_W), .QUO_W(31), .SIDE_W($bits(st_side_t))) u_sdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p4_valid_reg),
        .in_rem    (p4_side_reg.ovf ? '0 : p4_rem_reg),
        .in_low    (p4_low_reg),
        .in_div    (p4_div_reg),
        .in_side   (p4_side_reg),
        .out_valid (sdiv_valid),
        .out_quo   (sdiv_quo),
        .out_side  (sside_out)
    );

    always_comb begin
        smag    = sside_out.ovf ? MAX_POS[30:0] : sdiv_quo;
        nw_full = sside_out.neg ? 34'(sside_out.w) + 34'(smag)
                                : 34'(sside_out.w) - 34'(smag);
        out_next.out_index = sside_out.idx;
        out_next.saturated = sside_out.sat || sside_out.ovf;
        if (nw_full > 34'sh0_7FFF_FFFF) begin
            out_next.new_weight = 32'sh7FFF_FFFF;
            out_next.saturated  = 1'b1;
        end else if (nw_full < -34'sh0_8000_0000) begin
            out_next.new_weight = 32'sh8000_0000;
            out_next.saturated  = 1'b1;
        end else begin
            out_next.new_weight = nw_full[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= sdiv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= out_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    `AWU_ASSERT_NOW(a_no_input_while_clearing, clr_busy_reg, !s_ready)
    `AWU_ASSERT_NEXT(a_clearing_runs_once, !clr_busy_reg, !clr_busy_reg)
    `AWU_ASSERT_NOW(a_held_result_stalls_pipe, out_valid_reg && !m_ready && sdiv_valid, !en)
    `AWU_ASSERT_NOW(a_powers_at_most_one, 1'b1, (pow1_reg <= ONE_Q32) && (pow2_reg <= ONE_Q32))
    `AWU_ASSERT_NOW(a_div_lanes_aligned, 1'b1, mdiv_valid == vdiv_valid)

endmodule

>>> rtl/awu_ram.sv
// Generic simple dual-port RAM with registered read.
// Depends on nothing; instantiated for each moment store.
module awu_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/awu_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband data.
// Uses awu_pkg; instantiated by the top level for bias correction and step size.
module awu_div_pipe #(
    parameter int DIV_W  = 33,
    parameter int QUO_W  = 32,
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DIV_W-1:0]  in_rem,
    input  logic [QUO_W-1:0]  in_low,
    input  logic [DIV_W-1:0]  in_div,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  out_quo,
    output logic [SIDE_W-1:0] out_side
);
    import awu_pkg::*;

    logic              valid_reg [QUO_W];
    logic [DIV_W-1:0]  rem_reg   [QUO_W];
    logic [QUO_W-1:0]  low_reg   [QUO_W];
    logic [QUO_W-1:0]  quo_reg   [QUO_W];
    logic [DIV_W-1:0]  div_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];

    logic              valid_c [QUO_W+1];
    logic [DIV_W-1:0]  rem_c   [QUO_W+1];
    logic [QUO_W-1:0]  low_c   [QUO_W+1];
    logic [QUO_W-1:0]  quo_c   [QUO_W+1];
    logic [DIV_W-1:0]  div_c   [QUO_W+1];
    logic [SIDE_W-1:0] side_c  [QUO_W+1];

    logic [DIV_W-1:0]  rem_next [QUO_W];
    logic [QUO_W-1:0]  quo_next [QUO_W];
    logic [DIV_W:0]    trial    [QUO_W];
    logic              ge       [QUO_W];

    always_comb begin
        valid_c[0] = in_valid;
        rem_c[0]   = in_rem;
        low_c[0]   = in_low;
        quo_c[0]   = '0;
        div_c[0]   = in_div;
        side_c[0]  = in_side;
        for (int k = 0; k < QUO_W; k++) begin
            valid_c[k+1] = valid_reg[k];
            rem_c[k+1]   = rem_reg[k];
            low_c[k+1]   = low_reg[k];
            quo_c[k+1]   = quo_reg[k];
            div_c[k+1]   = div_reg[k];
            side_c[k+1]  = side_reg[k];
        end
        for (int k = 0; k < QUO_W; k++) begin
            trial[k]    = {rem_c[k], low_c[k][QUO_W-1]};
            ge[k]       = trial[k] >= {1'b0, div_c[k]};
            rem_next[k] = ge[k] ? DIV_W'(trial[k] - {1'b0, div_c[k]}) : trial[k][DIV_W-1:0];
            quo_next[k] = {quo_c[k][QUO_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < QUO_W; k++) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_c[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QUO_W; k++) begin
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= {low_c[k][QUO_W-2:0], 1'b0};
                quo_reg[k]  <= quo_next[k];
                div_reg[k]  <= div_c[k];
                side_reg[k] <= side_c[k];
            end
        end
    end

    assign out_valid = valid_c[QUO_W];
    assign out_quo   = quo_c[QUO_W];
    assign out_side  = side_c[QUO_W];

endmodule
